// ===== sv/ild_pkg.sv =====
// ----------------------------------------------------------------------------
// ild_pkg
// Shared types and constants of the indexed list deque: operation and status
// codes, and the command that the top level broadcasts to its row of cells.
// ----------------------------------------------------------------------------
package ild_pkg;

   // Default number of cells in the row.
   localparam int CAPACITY_DEFAULT = 16;

   // Fixed widths of the transaction fields.
   localparam int FUNC_W = 2;
   localparam int POS_W = 5;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_BAD  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // Command seen by every cell in the cycle a request is taken.
   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] data;
   } ild_cmd_type;

endpackage

// ===== sv/ild_if.sv =====
// ----------------------------------------------------------------------------
// ild_req_if / ild_rsp_if
// Valid/ready channels that carry the request and response transactions.
// ----------------------------------------------------------------------------
interface ild_req_if;
   logic                             valid;
   logic                             ready;
   logic [ild_pkg::FUNC_W-1:0]       func;
   logic [ild_pkg::POS_W-1:0]        position;
   logic signed [ild_pkg::DATA_W-1:0] data_in;

   modport source (output valid, output func, output position, output data_in,
                   input ready);
   modport sink (input valid, input func, input position, input data_in,
                 output ready);
endinterface

interface ild_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ild_pkg::STATUS_W-1:0]      status;
   logic signed [ild_pkg::DATA_W-1:0] data_out;
   logic [ild_pkg::COUNT_W-1:0]       count;
   logic signed [ild_pkg::DATA_W-1:0] front_value;
   logic signed [ild_pkg::DATA_W-1:0] back_value;

   modport source (output valid, output status, output data_out, output count,
                   output front_value, output back_value, input ready);
   modport sink (input valid, input status, input data_out, input count,
                 input front_value, input back_value, output ready);
endinterface

// ===== sv/ild_cell.sv =====
// ----------------------------------------------------------------------------
// ild_cell
// One storage cell of the list. It holds the value at its own position and
// takes its neighbour's value when an insert or delete shifts the list.
// ----------------------------------------------------------------------------
module ild_cell #(
   parameter int IDX   = 0,
   parameter int CMP_W = ild_pkg::POS_W
) (
   input  logic                              clock,
   input  ild_pkg::ild_cmd_type              cmd,
   input  logic [CMP_W-1:0]                  count,
   input  logic signed [ild_pkg::DATA_W-1:0] left_value,
   input  logic signed [ild_pkg::DATA_W-1:0] right_value,
   output logic signed [ild_pkg::DATA_W-1:0] value,
   output logic signed [ild_pkg::DATA_W-1:0] pos_tap,
   output logic signed [ild_pkg::DATA_W-1:0] last_tap
);

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);
   localparam logic [CMP_W-1:0] MY_END = CMP_W'(IDX + 1);

   logic signed [ild_pkg::DATA_W-1:0] value_ff;
   logic signed [ild_pkg::DATA_W-1:0] value_in;
   logic [CMP_W-1:0]                  pos_ext;

   assign pos_ext = CMP_W'(cmd.pos);

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (MY_IDX > pos_ext) begin
            value_in = left_value;
         end else if (MY_IDX == pos_ext) begin
            value_in = cmd.data;
         end
      end else if (cmd.del) begin
         if (MY_IDX >= pos_ext) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value    = value_ff;
   assign pos_tap  = (MY_IDX == pos_ext) ? value_ff : '0;
   assign last_tap = (MY_END == count) ? value_ff : '0;

endmodule

// ===== sv/indexed_list_deque.sv =====
// Response path: the edge that takes a request loads the first stage, and
// the first stage moves into the response register when that is empty or
// being emptied. Throughput: one transaction per cycle while the response
// channel does not stall; the row of cells shifts in the cycle a request is
// taken, and the front and back values are read from it as the first stage
// moves on, while the next request may already be being applied.
// Reset clears the count and both pipeline stages; cell contents are left
// as they are and are never read before being written.
// ----------------------------------------------------------------------------
// indexed_list_deque
// Bounded ordered list of signed values with insert and delete at any
// position, built as a row of shifting cells with a two-stage response path.
// ----------------------------------------------------------------------------
module indexed_list_deque #(
   parameter int CAPACITY = ild_pkg::CAPACITY_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ild_req_if.sink   req_chan,
   ild_rsp_if.source rsp_chan
);

   // Width of the internal count, and of the compare width, which must also
   // hold any position the request field can carry.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > ild_pkg::POS_W) ? CNT_W : ild_pkg::POS_W;
   localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

   // The list: one cell per position, front at cell zero.
   logic signed [ild_pkg::DATA_W-1:0] cell_value [CAPACITY];
   logic signed [ild_pkg::DATA_W-1:0] pos_tap [CAPACITY];
   logic signed [ild_pkg::DATA_W-1:0] last_tap [CAPACITY];

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] pos_ext;

   ild_pkg::ild_cmd_type cmd;
   ild_pkg::status_type  status_next;
   logic signed [ild_pkg::DATA_W-1:0] moved_next;
   logic signed [ild_pkg::DATA_W-1:0] pos_value;
   logic signed [ild_pkg::DATA_W-1:0] back_value;
   logic signed [ild_pkg::DATA_W-1:0] front_value;

   // The first stage holds the status and moved value of an operation that
   // has been applied to the cells; the second is the response register.
   logic                              pend_valid_ff;
   logic                              pend_valid_in;
   ild_pkg::status_type               pend_status_ff;
   logic signed [ild_pkg::DATA_W-1:0] pend_data_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   ild_pkg::status_type               rsp_status_ff;
   logic signed [ild_pkg::DATA_W-1:0] rsp_data_ff;
   logic [ild_pkg::COUNT_W-1:0]       rsp_count_ff;
   logic signed [ild_pkg::DATA_W-1:0] rsp_front_ff;
   logic signed [ild_pkg::DATA_W-1:0] rsp_back_ff;

   logic req_accept;
   logic rsp_load;

   // The response register can load when it is empty or being emptied, and
   // a request can be taken when the first stage is empty or moving on.
   assign rsp_load       = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !pend_valid_ff || rsp_load;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign count_ext = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_chan.position);

   // The row of cells. Each cell sees its neighbours; the ends see their
   // own value, which a valid shift never moves into the list itself.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [ild_pkg::DATA_W-1:0] left_value;
      logic signed [ild_pkg::DATA_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = cell_value[g];
      end else begin : g_inner_l
         assign left_value = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner_r
         assign right_value = cell_value[g+1];
      end

      ild_cell #(
         .IDX   (g),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ext),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[g]),
         .pos_tap     (pos_tap[g]),
         .last_tap    (last_tap[g])
      );
   end

   // At most one cell drives each tap, so the selected values are ORed.
   always_comb begin
      pos_value  = '0;
      back_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pos_value  = pos_value | pos_tap[i];
         back_value = back_value | last_tap[i];
      end
   end

   assign front_value = (count_ff == '0) ? '0 : cell_value[0];

   // Decode of the request. Nothing changes unless a request is taken.
   always_comb begin
      cmd.ins     = 1'b0;
      cmd.del     = 1'b0;
      cmd.pos     = req_chan.position;
      cmd.data    = req_chan.data_in;
      count_in    = count_ff;
      status_next = ild_pkg::ST_BAD;
      moved_next  = '0;
      case (ild_pkg::func_type'(req_chan.func))
         ild_pkg::FUNC_INSERT: begin
            if (pos_ext > count_ext) begin
               status_next = ild_pkg::ST_BAD;
            end else if (count_ext >= CAP_CMP) begin
               status_next = ild_pkg::ST_FULL;
            end else begin
               status_next = ild_pkg::ST_OK;
               moved_next  = req_chan.data_in;
               cmd.ins     = req_accept;
               if (req_accept) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ild_pkg::FUNC_DELETE: begin
            if (pos_ext >= count_ext) begin
               status_next = ild_pkg::ST_BAD;
            end else begin
               status_next = ild_pkg::ST_OK;
               moved_next  = pos_value;
               cmd.del     = req_accept;
               if (req_accept) begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         ild_pkg::FUNC_CLEAR: begin
            status_next = ild_pkg::ST_OK;
            if (req_accept) begin
               count_in = '0;
            end
         end
         default: begin
            status_next = ild_pkg::ST_BAD;
         end
      endcase
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_accept) begin
         pend_valid_in = 1'b1;
      end else if (rsp_load) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers. The response takes the count and end values from
   // the cells as they stand after the pending operation was applied.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pend_status_ff <= status_next;
         pend_data_ff   <= moved_next;
      end
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_data_ff   <= pend_data_ff;
         rsp_count_ff  <= ild_pkg::COUNT_W'(count_ff);
         rsp_front_ff  <= front_value;
         rsp_back_ff   <= back_value;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.data_out    = rsp_data_ff;
   assign rsp_chan.count       = rsp_count_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.back_value  = rsp_back_ff;

endmodule

// ===== sv/ild_checker.sv =====
// ----------------------------------------------------------------------------
// ild_checker
// Port-level checks on the response transactions of the indexed list deque.
// ----------------------------------------------------------------------------
module ild_checker #(
   parameter int CAPACITY = ild_pkg::CAPACITY_DEFAULT
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ild_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [ild_pkg::DATA_W-1:0] rsp_data_out,
   input logic [ild_pkg::COUNT_W-1:0]       rsp_count,
   input logic signed [ild_pkg::DATA_W-1:0] rsp_front_value,
   input logic signed [ild_pkg::DATA_W-1:0] rsp_back_value
);

   localparam logic [ild_pkg::COUNT_W-1:0] CAP_COUNT = ild_pkg::COUNT_W'(CAPACITY);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_count) && $stable(rsp_status))
      else $error("stalled response changed");

   // An empty list reports zero at both ends.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 |-> rsp_front_value == '0 && rsp_back_value == '0)
      else $error("empty list reports non-zero end values");

   // A full status is only given when the list is at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ild_pkg::ST_FULL |-> rsp_count == CAP_COUNT)
      else $error("full status below capacity");

   // A rejected operation moves no value.
   a_bad_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ild_pkg::ST_OK |-> rsp_data_out == '0)
      else $error("rejected operation returned data");

endmodule

bind indexed_list_deque ild_checker #(
   .CAPACITY (CAPACITY)
) u_ild_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_data_out    (rsp_chan.data_out),
   .rsp_count       (rsp_chan.count),
   .rsp_front_value (rsp_chan.front_value),
   .rsp_back_value  (rsp_chan.back_value)
);

// ===== bench/tb_indexed_list_deque.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_list_deque
// Self-checking bench for the indexed list deque. A directed table covers
// the range limits, every operation and each error case. Random traffic then
// grows and drains the list. Every response is compared field by field with
// a behavioural list kept alongside the design, under changing handshake
// pressure on both channels.
// ----------------------------------------------------------------------------
module tb_indexed_list_deque;

   timeunit 1ns;
   timeprecision 1ps;

   import ild_pkg::*;

   localparam int CAP = CAPACITY_DEFAULT;

   // The func field has one code that the package leaves unnamed. It must do
   // nothing and report a bad status.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // Number of random transactions in each idling phase, and the length of
   // the long receiver hold-off that backs the pipeline up into the request
   // channel.
   localparam int PHASE_ITEMS = 375;
   localparam int LONG_HOLD = 80;

   // One response, as the design should report it.
   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] data_out;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
   } list_result_type;

   // One row of the directed table. A row is sent reps times, and the data
   // value steps up by one on each repeat. Where typed is set, the response
   // is checked against want. Otherwise it is checked against the list model.
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic [4:0]               reps;
      logic                     typed;
      list_result_type          want;
   } directed_row_type;

   // Responses that can be read straight off the operation.
   localparam list_result_type EMPTY_BAD = '{ST_BAD, 32'sd0, 5'd0, 32'sd0, 32'sd0};
   localparam list_result_type EMPTY_OK  = '{ST_OK, 32'sd0, 5'd0, 32'sd0, 32'sd0};

   logic clock;
   logic reset;

   ild_req_if req_if ();
   ild_rsp_if rsp_if ();

   indexed_list_deque u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Behavioural copy of the list. The front is at index zero.
   logic signed [DATA_W-1:0] list_vals [CAP];
   int                       list_len;

   // Expected responses, oldest first, added when their request is taken.
   list_result_type pending_results [$];
   directed_row_type directed_ops [$];

   int mismatch_count;
   int send_idle_pct;
   int recv_stall_pct;
   bit long_hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one operation to the list model and return the response that the
   // design should produce for it.
   function automatic list_result_type predict_list_op(input logic [FUNC_W-1:0] func,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic signed [DATA_W-1:0] value);
      list_result_type r;
      int i;
      r = '0;
      r.status = ST_OK;
      case (func)
         FUNC_INSERT: begin
            if (pos > list_len) begin
               r.status = ST_BAD;
            end else if (list_len >= CAP) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_len; i > pos; i--)
                  list_vals[i] = list_vals[i-1];
               list_vals[pos] = value;
               list_len++;
               r.data_out = value;
            end
         end
         FUNC_DELETE: begin
            if (pos >= list_len) begin
               r.status = ST_BAD;
            end else begin
               r.data_out = list_vals[pos];
               for (i = pos; i + 1 < list_len; i++)
                  list_vals[i] = list_vals[i+1];
               list_len--;
            end
         end
         FUNC_CLEAR: begin
            list_len = 0;
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      r.count = list_len[COUNT_W-1:0];
      if (list_len != 0) begin
         r.front_value = list_vals[0];
         r.back_value = list_vals[list_len-1];
      end
      return r;
   endfunction

   task automatic add_row(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] value, input int reps,
                          input bit typed, input list_result_type want);
      directed_row_type row;
      row.func = func;
      row.pos = pos;
      row.value = value;
      row.reps = reps[4:0];
      row.typed = typed;
      row.want = want;
      directed_ops.insert(directed_ops.size(), row);
   endtask

   // Offer one request transaction and hold it until it is taken. The
   // expectation is recorded at the edge that takes it. A random idle gap may
   // follow, and valid is lowered only when the sender really goes idle.
   task automatic send_op(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] value, input bit typed,
                          input list_result_type want);
      list_result_type predicted;
      req_if.valid <= 1'b1;
      req_if.func <= func;
      req_if.position <= pos;
      req_if.data_in <= value;
      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);
      predicted = predict_list_op(func, pos, value);
      pending_results.insert(pending_results.size(), typed ? want : predicted);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d (0x%08h), actual %0d (0x%08h)",
                  $time, name, $signed(want), want, $signed(got), got);
         mismatch_count++;
      end
   endtask

   // Response side. Each accepted transaction is checked against the oldest
   // expectation. Then ready for the next cycle is chosen. A long hold-off,
   // once it is requested, is counted down here and overrides the random
   // stalls.
   initial begin : rsp_sink
      int hold_left;
      list_result_type want;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               $display({"%0t: unexpected response, expected none, ",
                         "actual status=%0d data=%0d count=%0d"},
                        $time, rsp_if.status, rsp_if.data_out, rsp_if.count);
               mismatch_count++;
            end else begin
               want = pending_results[0];
               pending_results.delete(0);
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_if.status));
               check_field("data_out", want.data_out, rsp_if.data_out);
               check_field("count", DATA_W'(want.count), DATA_W'(rsp_if.count));
               check_field("front_value", want.front_value, rsp_if.front_value);
               check_field("back_value", want.back_value, rsp_if.back_value);
            end
         end
         if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin : stimulus
      int rep;
      int phase;
      int n;
      int ins_pct;
      int pick;
      int hi;
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0] pos;
      logic signed [DATA_W-1:0] value;

      mismatch_count = 0;
      list_len = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold_req = 1'b0;
      ins_pct = 50;
      req_if.valid <= 1'b0;
      req_if.func <= FUNC_INSERT;
      req_if.position <= '0;
      req_if.data_in <= '0;
      reset <= 1'b1;

      // Directed table. An empty list first: every error case, the unused
      // code and a clear. Then the value extremes at both ends, and a fill
      // from the front up to capacity. A full list must refuse inserts even
      // at valid positions. Pops at either end and in the middle follow, and
      // a final clear.
      add_row(FUNC_DELETE, 5'd0, 32'sd0, 1, 1'b1, EMPTY_BAD);
      add_row(FUNC_INSERT, 5'd1, 32'sh5A5A5A5A, 1, 1'b1, EMPTY_BAD);
      add_row(FUNC_INSERT, 5'd31, -32'sd1, 1, 1'b1, EMPTY_BAD);
      add_row(FUNC_UNUSED, 5'd0, 32'sh7FFFFFFF, 1, 1'b1, EMPTY_BAD);
      add_row(FUNC_CLEAR, 5'd0, 32'sd0, 1, 1'b1, EMPTY_OK);
      add_row(FUNC_INSERT, 5'd0, 32'sh7FFFFFFF, 1, 1'b1,
              '{ST_OK, 32'sh7FFFFFFF, 5'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
      add_row(FUNC_INSERT, 5'd1, 32'sh80000000, 1, 1'b1,
              '{ST_OK, 32'sh80000000, 5'd2, 32'sh7FFFFFFF, 32'sh80000000});
      add_row(FUNC_DELETE, 5'd2, 32'sd0, 1, 1'b1,
              '{ST_BAD, 32'sd0, 5'd2, 32'sh7FFFFFFF, 32'sh80000000});
      add_row(FUNC_INSERT, 5'd1, -32'sd1, 1, 1'b0, '0);
      add_row(FUNC_DELETE, 5'd1, 32'sd0, 1, 1'b0, '0);
      add_row(FUNC_INSERT, 5'd0, 32'sh10000000, 14, 1'b0, '0);
      add_row(FUNC_INSERT, 5'd0, 32'sh0BADF00D, 1, 1'b0, '0);
      add_row(FUNC_INSERT, 5'd16, 32'sh0BADF00D, 1, 1'b0, '0);
      add_row(FUNC_INSERT, 5'd17, 32'sh0BADF00D, 1, 1'b0, '0);
      add_row(FUNC_DELETE, 5'd16, 32'sd0, 1, 1'b0, '0);
      add_row(FUNC_DELETE, 5'd15, 32'sd0, 1, 1'b0, '0);
      add_row(FUNC_DELETE, 5'd0, 32'sd0, 1, 1'b0, '0);
      add_row(FUNC_DELETE, 5'd7, 32'sd0, 1, 1'b0, '0);
      add_row(FUNC_INSERT, 5'd13, 32'sh00C0FFEE, 1, 1'b0, '0);
      add_row(FUNC_UNUSED, 5'd31, -32'sd5, 1, 1'b0, '0);
      add_row(FUNC_CLEAR, 5'd0, 32'sd0, 1, 1'b1, EMPTY_OK);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[k]) begin
         for (rep = 0; rep < directed_ops[k].reps; rep++)
            send_op(directed_ops[k].func, directed_ops[k].pos, directed_ops[k].value + rep,
                    directed_ops[k].typed, directed_ops[k].want);
      end

      // Random traffic in four idling phases. Before each phase the sender
      // goes quiet until the response queue has drained completely.
      for (phase = 0; phase < 4; phase++) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while (pending_results.size() != 0)
            @(posedge clock);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Changing the insert bias every so often lets the list fill to
            // capacity, drain to empty and wander in between.
            if (n % 64 == 0) begin
               case ($urandom_range(2))
                  0: ins_pct = 85;
                  1: ins_pct = 50;
                  default: ins_pct = 15;
               endcase
            end
            // While the receiver holds off with no idling, the sender keeps
            // offering, so the pipeline fills and ready must drop.
            if (phase == 0 && n == 100)
               long_hold_req = 1'b1;

            pick = $urandom_range(99);
            if (pick < 2) begin
               func = FUNC_CLEAR;
               pos = POS_W'($urandom_range(31));
            end else if (pick < 4) begin
               func = FUNC_UNUSED;
               pos = POS_W'($urandom_range(31));
            end else if (pick < 12) begin
               // Noise: a position anywhere in the field's range.
               func = $urandom_range(1) ? FUNC_INSERT : FUNC_DELETE;
               pos = POS_W'($urandom_range(31));
            end else begin
               func = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
               hi = (func == FUNC_INSERT) ? list_len : list_len - 1;
               if (hi < 0)
                  hi = 0;
               case ($urandom_range(3))
                  0: pos = '0;
                  1: pos = hi[POS_W-1:0];
                  default: pos = POS_W'($urandom_range(hi));
               endcase
            end
            case ($urandom_range(19))
               0: value = 32'sh7FFFFFFF;
               1: value = 32'sh80000000;
               2: value = 32'sd0;
               3: value = -32'sd1;
               default: value = $urandom;
            endcase
            send_op(func, pos, value, 1'b0, '0);
         end
      end

      // Let every outstanding response arrive, then keep waiting past the
      // response latency, so that a stray extra response is caught.
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // This limit is far above the length of a correct run.
   initial begin : watchdog
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
